// ===== rtl/core/ppa_pkg.sv =====
// Shared codes and field types for the page pool allocator.
`default_nettype none

package ppa_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [2:0] t_status;
    typedef logic [0:0] t_cfg_idx;

    localparam t_kind KIND_ALLOC   = 2'd0;
    localparam t_kind KIND_RELEASE = 2'd1;
    localparam t_kind KIND_XLATE   = 2'd2;

    localparam t_status ST_OK            = 3'd0;
    localparam t_status ST_POOL_EMPTY    = 3'd1;
    localparam t_status ST_BAD_INDEX     = 3'd2;
    localparam t_status ST_NOT_COMMITTED = 3'd3;
    localparam t_status ST_OUTSIDE_POOL  = 3'd4;

    localparam t_cfg_idx REG_PAGE_COUNT   = 1'd0;
    localparam t_cfg_idx REG_BASE_ADDRESS = 1'd1;

endpackage

`default_nettype wire

// ===== rtl/core/ppa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/page_pool_allocator_core.sv =====
// Page pool allocator: free-page stack and committed bitmap held in RAM.
//
// Each transaction has an accept cycle, which issues the RAM reads (free
// stack at top-1, committed bitmap at the page of interest), and an execute
// state, which modifies and writes back both RAMs and loads the result
// register and waits while the result register holds an untaken result.
// After reset and after every page_count write the committed bitmap is
// cleared by a pass over all MAX_PAGES entries, one entry a cycle; no item
// is accepted meanwhile. Stack entries below the lowest top reached since
// the last refill are never read from RAM; they read as their own position.
`default_nettype none

module page_pool_allocator_core #(
    parameter int MAX_PAGES  = 256,
    parameter int PAGE_SHIFT = 16,
    parameter int ADDR_BITS  = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire ppa_pkg::t_cfg_idx  i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ppa_pkg::t_kind     i_kind,
    input  wire logic [7:0]         i_page_index,
    input  wire logic [31:0]        i_address,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ppa_pkg::t_status        o_status,
    output logic [7:0]              o_result_index,
    output logic [31:0]             o_page_address,
    output logic                    o_page_committed,
    output logic [8:0]              o_committed_count
);

    import ppa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PAGES);
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int CW     = CNT_W + 9;
    localparam int PG_W   = 32 - PAGE_SHIFT;
    localparam int TW     = PG_W + CNT_W;
    localparam int PC_RST = (MAX_PAGES < 256) ? MAX_PAGES : 256;
    localparam logic [31:0] A_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(MAX_PAGES - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PAGES);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    // control state
    logic [1:0]       r_state;
    logic [IDX_W-1:0] r_clr;
    logic [CNT_W-1:0] r_page_count;
    logic [31:0]      r_base;
    logic [CNT_W-1:0] r_top;
    logic [CNT_W-1:0] r_low;
    logic [CNT_W-1:0] r_total;
    logic             r_out_valid;

    // latched transaction
    t_kind            r_kind;
    logic             r_pidx_ok;
    logic             r_xl_ok;
    logic             r_pop_mem;
    logic [IDX_W-1:0] r_idx;

    // result register
    t_status          r_out_status;
    logic [7:0]       r_out_index;
    logic [31:0]      r_out_addr;
    logic             r_out_committed;
    logic [8:0]       r_out_count;

    logic             w_accept;
    logic             w_go;
    logic [32:0]      w_diff;
    logic [PG_W-1:0]  w_pg;
    logic [TW-1:0]    w_pg_cmp;
    logic [TW-1:0]    w_pc_cmp;
    logic [IDX_W+PG_W-1:0] w_pg_ext;
    logic [IDX_W+7:0] w_pidx_ext;
    logic [CW-1:0]    w_pidx_cmp;
    logic [CW-1:0]    w_pc_cw;
    logic             w_xl_ok;
    logic             w_pidx_ok;
    logic [IDX_W-1:0] w_in_idx;
    logic [CNT_W-1:0] w_top_m1;

    logic [IDX_W-1:0] stk_rdata;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    logic             map_rdata;
    logic             map_we;
    logic [IDX_W-1:0] map_waddr;
    logic             map_wdata;
    logic [IDX_W-1:0] map_raddr;

    logic             x_map_we;
    logic [IDX_W-1:0] x_map_waddr;
    logic             x_map_wdata;
    logic             x_stk_we;
    logic [IDX_W-1:0] x_pop_idx;
    logic [CNT_W-1:0] n_top;
    logic [CNT_W-1:0] n_low;
    logic [CNT_W-1:0] n_total;
    t_status          x_status;
    logic             x_ok;
    logic [IDX_W-1:0] x_idx;
    logic             x_commit;

    logic [IDX_W+PAGE_SHIFT+31:0] w_sh;
    logic [31:0]      w_paddr;
    logic [IDX_W+7:0] w_idx_ext;
    logic [CW-1:0]    w_total_ext;

    logic [8:0]       w_cfg_pc9;
    logic [CW-1:0]    w_cfg_ext;
    logic [CW-1:0]    w_cfg_clamp;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_go       = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // translate: offset from base, page number, range check
    assign w_diff   = {1'b0, i_address} - {1'b0, r_base};
    assign w_pg     = w_diff[31:PAGE_SHIFT];
    assign w_pg_cmp = {{CNT_W{1'b0}}, w_pg};
    assign w_pc_cmp = {{PG_W{1'b0}}, r_page_count};
    assign w_xl_ok  = !w_diff[32] && (w_pg_cmp < w_pc_cmp);
    assign w_pg_ext = {{IDX_W{1'b0}}, w_pg};

    // release: index check against the page count
    assign w_pidx_ext = {{IDX_W{1'b0}}, i_page_index};
    assign w_pidx_cmp = {{(CNT_W + 1){1'b0}}, i_page_index};
    assign w_pc_cw    = {9'd0, r_page_count};
    assign w_pidx_ok  = (w_pidx_cmp < w_pc_cw);

    assign w_in_idx = (i_kind == KIND_RELEASE) ? w_pidx_ext[IDX_W-1:0]
                                               : w_pg_ext[IDX_W-1:0];
    assign w_top_m1 = r_top - CNT_W'(1);

    // hold the read addresses steady while the transaction waits
    assign map_raddr = (r_state == S_IDLE) ? w_in_idx : r_idx;

    ppa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PAGES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_idx),
        .i_raddr (w_top_m1[IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    ppa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PAGES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    assign x_pop_idx = r_pop_mem ? stk_rdata : w_top_m1[IDX_W-1:0];

    always_comb begin
        n_top       = r_top;
        n_low       = r_low;
        n_total     = r_total;
        x_map_we    = 1'b0;
        x_map_waddr = r_idx;
        x_map_wdata = 1'b0;
        x_stk_we    = 1'b0;
        x_status    = ST_OK;
        x_ok        = 1'b0;
        x_idx       = r_idx;
        x_commit    = 1'b0;
        unique case (r_kind)
            KIND_ALLOC: begin
                if (r_top == '0) begin
                    x_status = ST_POOL_EMPTY;
                end else begin
                    x_ok        = 1'b1;
                    x_idx       = x_pop_idx;
                    x_commit    = 1'b1;
                    n_top       = w_top_m1;
                    n_low       = (w_top_m1 < r_low) ? w_top_m1 : r_low;
                    x_map_we    = 1'b1;
                    x_map_waddr = x_pop_idx;
                    x_map_wdata = 1'b1;
                    n_total     = r_total + CNT_W'(1);
                end
            end
            KIND_RELEASE: begin
                if (!r_pidx_ok) begin
                    x_status = ST_BAD_INDEX;
                end else if (!map_rdata) begin
                    x_status = ST_NOT_COMMITTED;
                end else begin
                    x_ok     = 1'b1;
                    x_map_we = 1'b1;
                    if (r_total != '0) begin
                        n_total = r_total - CNT_W'(1);
                    end
                    if (r_top < CNT_MAX) begin
                        x_stk_we = 1'b1;
                        n_top    = r_top + CNT_W'(1);
                    end
                end
            end
            KIND_XLATE: begin
                if (!r_xl_ok) begin
                    x_status = ST_OUTSIDE_POOL;
                end else begin
                    x_ok     = 1'b1;
                    x_commit = map_rdata;
                end
            end
            default: begin
                // no operation
            end
        endcase
    end

    // bitmap writes come from the clearing pass or from write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            map_we    = 1'b1;
            map_waddr = r_clr;
            map_wdata = 1'b0;
        end else begin
            map_we    = w_go && x_map_we;
            map_waddr = x_map_waddr;
            map_wdata = x_map_wdata;
        end
    end

    assign stk_we    = w_go && x_stk_we;
    assign stk_waddr = r_top[IDX_W-1:0];

    assign w_sh        = {32'd0, x_idx, {PAGE_SHIFT{1'b0}}};
    assign w_paddr     = (r_base + w_sh[31:0]) & A_MASK;
    assign w_idx_ext   = {8'd0, x_idx};
    assign w_total_ext = {9'd0, n_total};

    // page count write: zero taken as one, saturate at the pool size
    assign w_cfg_pc9 = i_cfg_data[8:0];
    assign w_cfg_ext = {{CNT_W{1'b0}}, w_cfg_pc9};
    always_comb begin
        if (w_cfg_pc9 == 9'd0) begin
            w_cfg_clamp = CW'(1);
        end else if (w_cfg_ext > CW'(MAX_PAGES)) begin
            w_cfg_clamp = CW'(MAX_PAGES);
        end else begin
            w_cfg_clamp = w_cfg_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_page_count <= CNT_W'(PC_RST);
            r_base       <= '0;
            r_top        <= CNT_W'(PC_RST);
            r_low        <= CNT_W'(PC_RST);
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // refill the pool on a page count write
            if (i_cfg_we && (i_cfg_idx == REG_PAGE_COUNT)) begin
                r_page_count <= w_cfg_clamp[CNT_W-1:0];
                r_top        <= w_cfg_clamp[CNT_W-1:0];
                r_low        <= w_cfg_clamp[CNT_W-1:0];
                r_total      <= '0;
                r_clr        <= '0;
                r_state      <= S_CLEAR;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + IDX_W'(1);
                        if (r_clr == LAST_ROW) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (w_accept) begin
                            r_state <= S_EXEC;
                        end
                    end
                    S_EXEC: begin
                        if (w_go) begin
                            r_top   <= n_top;
                            r_low   <= n_low;
                            r_total <= n_total;
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end

            if (i_cfg_we && (i_cfg_idx == REG_BASE_ADDRESS)) begin
                r_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= i_kind;
            r_pidx_ok <= w_pidx_ok;
            r_xl_ok   <= w_xl_ok;
            r_pop_mem <= (r_top > r_low);
            r_idx     <= w_in_idx;
        end
        if (w_go) begin
            r_out_status    <= x_status;
            r_out_index     <= x_ok ? w_idx_ext[7:0] : 8'd0;
            r_out_addr      <= x_ok ? w_paddr : 32'd0;
            r_out_committed <= x_ok && x_commit;
            r_out_count     <= w_total_ext[8:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_result_index    = r_out_index;
    assign o_page_address    = r_out_addr;
    assign o_page_committed  = r_out_committed;
    assign o_committed_count = r_out_count;

endmodule

`default_nettype wire

// ===== tb/sv/tb_page_pool_allocator_core.sv =====
// Self-checking testbench for the page pool allocator core.
`timescale 1ns / 1ps

module tb_page_pool_allocator_core;
    import ppa_pkg::*;

    localparam int POOL_MAX_PAGES  = 256;
    localparam int POOL_PAGE_SHIFT = 16;
    localparam int STUCK_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 128;

    localparam t_kind KIND_NOP = 2'd3;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  page_index;
        logic [31:0] address;
    } t_pool_req;

    typedef struct packed {
        t_status     status;
        logic [7:0]  index;
        logic [31:0] page_addr;
        logic        committed;
        logic [8:0]  count;
    } t_pool_reply;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    t_cfg_idx    i_cfg_idx    = REG_PAGE_COUNT;
    logic [31:0] i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    t_kind       i_kind       = KIND_ALLOC;
    logic [7:0]  i_page_index = '0;
    logic [31:0] i_address    = '0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_status     o_status;
    logic [7:0]  o_result_index;
    logic [31:0] o_page_address;
    logic        o_page_committed;
    logic [8:0]  o_committed_count;

    page_pool_allocator_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_page_index      (i_page_index),
        .i_address         (i_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_result_index    (o_result_index),
        .o_page_address    (o_page_address),
        .o_page_committed  (o_page_committed),
        .o_committed_count (o_committed_count)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the pool state and configuration
    logic [7:0]  free_pages [POOL_MAX_PAGES];
    bit          page_used  [POOL_MAX_PAGES];
    int unsigned free_top;
    int unsigned used_total;
    int unsigned page_limit;
    logic [31:0] pool_base;

    t_pool_req   pool_requests[$];
    t_pool_reply predicted_replies[$];
    int          requests_open   = 0;
    int          fail_count      = 0;
    int          replies_seen    = 0;
    int          stuck_cycles    = 0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    bit          hold_request    = 1'b0;
    int          hold_left       = 0;
    bit          in_taken        = 1'b0;

    function automatic void refill_pool();
        for (int i = 0; i < POOL_MAX_PAGES; i++) begin
            free_pages[i] = i[7:0];
            page_used[i]  = 1'b0;
        end
        free_top   = page_limit;
        used_total = 0;
    endfunction

    function automatic t_pool_reply predict_pool_reply(t_pool_req req);
        t_pool_reply rep;
        bit          ok;
        int unsigned pg;
        logic [31:0] offset;
        rep        = '0;
        rep.status = ST_OK;
        ok         = 1'b0;
        pg         = 0;
        case (req.kind)
            KIND_ALLOC: begin
                if (free_top == 0) begin
                    rep.status = ST_POOL_EMPTY;
                end else begin
                    free_top--;
                    pg = 32'(free_pages[free_top]);
                    if (!page_used[pg]) begin
                        page_used[pg] = 1'b1;
                        used_total++;
                    end
                    ok = 1'b1;
                end
            end
            KIND_RELEASE: begin
                if (req.page_index >= page_limit) begin
                    rep.status = ST_BAD_INDEX;
                end else if (!page_used[req.page_index]) begin
                    rep.status = ST_NOT_COMMITTED;
                end else begin
                    page_used[req.page_index] = 1'b0;
                    if (used_total > 0) used_total--;
                    // a full stack cannot take the page back
                    if (free_top < POOL_MAX_PAGES) begin
                        free_pages[free_top] = req.page_index;
                        free_top++;
                    end
                    pg = 32'(req.page_index);
                    ok = 1'b1;
                end
            end
            KIND_XLATE: begin
                if (req.address < pool_base) begin
                    rep.status = ST_OUTSIDE_POOL;
                end else begin
                    offset = req.address - pool_base;
                    if ((offset >> POOL_PAGE_SHIFT) >= page_limit) begin
                        rep.status = ST_OUTSIDE_POOL;
                    end else begin
                        pg = offset >> POOL_PAGE_SHIFT;
                        ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (ok) begin
            rep.index     = pg[7:0];
            rep.page_addr = pool_base + (pg << POOL_PAGE_SHIFT);
            rep.committed = page_used[pg];
        end
        rep.count = used_total[8:0];
        return rep;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("reply %0d: %s expected 0x%0h, got 0x%0h", replies_seen, name,
                         want, got);
        end
    endtask

    // Write one register; the block is idle, so the shadow follows at once
    task automatic program_reg(t_cfg_idx idx, logic [31:0] data);
        int unsigned n;
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_PAGE_COUNT) begin
            n = {23'd0, data[8:0]};
            if (n == 0) n = 1;
            if (n > POOL_MAX_PAGES) n = POOL_MAX_PAGES;
            page_limit = n;
            refill_pool();
        end else begin
            pool_base = data;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic post_request(t_kind kind, logic [7:0] page_index, logic [31:0] address);
        pool_requests.push_back('{kind: kind, page_index: page_index, address: address});
        requests_open++;
    endtask

    task automatic post_random_request(int alloc_pct);
        t_kind       kind;
        logic [7:0]  page_index;
        logic [31:0] address;
        int          pick;
        page_index = 8'($urandom_range(255));
        address    = $urandom();
        pick       = $urandom_range(99);
        if (pick < alloc_pct) begin
            kind = KIND_ALLOC;
        end else begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                kind = KIND_RELEASE;
                if ($urandom_range(4) != 0) page_index = 8'($urandom_range(page_limit - 1));
            end else if (pick < 92) begin
                kind = KIND_XLATE;
                pick = $urandom_range(9);
                // mostly inside the pool, the page just past the end included
                if (pick < 7)
                    address = pool_base + ($urandom_range(page_limit) << POOL_PAGE_SHIFT)
                              + $urandom_range(16'hFFFF);
                else if (pick < 8)
                    address = pool_base - $urandom_range(16, 1);
            end else begin
                kind = KIND_NOP;
            end
        end
        post_request(kind, page_index, address);
    endtask

    task automatic wait_pool_idle();
        while (requests_open != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] count_word, logic [31:0] base_word, int mode,
                             int items, int alloc_pct, bit hold);
        wait_pool_idle();
        program_reg(REG_BASE_ADDRESS, base_word);
        program_reg(REG_PAGE_COUNT, count_word);
        @(posedge i_clk);
        case (mode)
            1:       begin sender_idle_pct = 53; recv_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  recv_stall_pct = 53; end
            3:       begin sender_idle_pct = 13; recv_stall_pct = 13; end
            default: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
        if (hold) hold_request = 1'b1;
        repeat (items) post_random_request(alloc_pct);
    endtask

    // Request driver: advance only after the current transaction is taken
    always @(negedge i_clk) begin : drive_requests
        t_pool_req req;
        if (!i_in_valid || in_taken) begin
            if (pool_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                req = pool_requests.pop_front();
                i_in_valid   <= 1'b1;
                i_kind       <= req.kind;
                i_page_index <= req.page_index;
                i_address    <= req.address;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch_pool
        t_pool_req   req;
        t_pool_reply want;
        in_taken = i_in_valid && (o_in_ready === 1'b1);
        if (in_taken) begin
            req = '{kind: i_kind, page_index: i_page_index, address: i_address};
            predicted_replies.push_back(predict_pool_reply(req));
        end
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            replies_seen++;
            if (predicted_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("reply %0d arrived with no request outstanding", replies_seen);
            end else begin
                want = predicted_replies.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("result_index", 32'(want.index), 32'(o_result_index));
                check_field("page_address", want.page_addr, o_page_address);
                check_field("page_committed", 32'(want.committed), 32'(o_page_committed));
                check_field("committed_count", 32'(want.count), 32'(o_committed_count));
                requests_open--;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] pick_count_word(int phase);
        logic [31:0] value;
        int          pick;
        pick = $urandom_range(9);
        if (phase == 0)      value = 1;
        else if (phase == 1) value = POOL_MAX_PAGES;
        else if (pick == 0)  value = POOL_MAX_PAGES;
        else if (pick == 1)  value = $urandom_range(1) ? 0 : 511;
        else                 value = $urandom_range(16, 1);
        // upper bits carry noise the block must drop
        return ($urandom() & 32'hFFFF_FE00) | value;
    endfunction

    function automatic logic [31:0] pick_base_word();
        int pick;
        pick = $urandom_range(9);
        if (pick < 7) return $urandom() & 32'hFFFF_0000;
        if (pick < 9) return $urandom();
        case ($urandom_range(2))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    initial begin
        page_limit = POOL_MAX_PAGES;
        pool_base  = '0;
        refill_pool();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default pool: 256 pages at address zero
        @(posedge i_clk);
        post_request(KIND_NOP, 8'hAA, $urandom());
        post_request(KIND_XLATE, 8'h00, 32'h0000_0000);
        post_request(KIND_ALLOC, 8'h00, 32'h0000_0000);
        post_request(KIND_XLATE, 8'h00, 32'h00FF_FFFF);
        post_request(KIND_XLATE, 8'h00, 32'h0100_0000);
        post_request(KIND_RELEASE, 8'hFF, 32'h0000_0000);
        post_request(KIND_RELEASE, 8'hFF, 32'h0000_0000);
        post_request(KIND_ALLOC, 8'h00, 32'h0000_0000);

        // Single page at the top of the address space; count written as zero
        wait_pool_idle();
        program_reg(REG_BASE_ADDRESS, 32'hFFFF_0000);
        program_reg(REG_PAGE_COUNT, 32'h0000_0000);
        @(posedge i_clk);
        post_request(KIND_ALLOC, 8'h00, 32'h0000_0000);
        post_request(KIND_ALLOC, 8'h00, 32'h0000_0000);
        post_request(KIND_XLATE, 8'h00, 32'hFFFE_FFFF);
        post_request(KIND_XLATE, 8'h00, 32'hFFFF_FFFF);
        post_request(KIND_RELEASE, 8'h01, 32'h0000_0000);
        post_request(KIND_RELEASE, 8'hFF, 32'h0000_0000);
        post_request(KIND_RELEASE, 8'h00, 32'h0000_0000);
        post_request(KIND_RELEASE, 8'h00, 32'h0000_0000);
        post_request(KIND_NOP, 8'hFF, 32'hFFFF_FFFF);

        // Oversized count saturates; page addresses wrap past the top
        wait_pool_idle();
        program_reg(REG_BASE_ADDRESS, 32'hFFF0_0000);
        program_reg(REG_PAGE_COUNT, 32'h0000_01FF);
        @(posedge i_clk);
        post_request(KIND_ALLOC, 8'h00, 32'h0000_0000);
        post_request(KIND_XLATE, 8'h00, 32'hFFFF_FFFF);
        post_request(KIND_XLATE, 8'h00, 32'h0000_0000);
        post_request(KIND_RELEASE, 8'hFF, 32'h0000_0000);
        post_request(KIND_ALLOC, 8'h00, 32'h0000_0000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
            run_phase(pick_count_word(phase), pick_base_word(), phase % 4, PHASE_ITEMS,
                      45, 1'b0);

        // Drain the full pool while results back up behind a long stall
        run_phase(($urandom() & 32'hFFFF_FE00) | POOL_MAX_PAGES, $urandom() & 32'hFFFF_0000,
                  0, 300, 92, 1'b1);

        wait_pool_idle();
        repeat (8) @(negedge i_clk);
        fail_count += predicted_replies.size();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ppa_pkg.sv
rtl/core/ppa_ram.sv
rtl/core/page_pool_allocator_core.sv
tb/sv/tb_page_pool_allocator_core.sv
